// File: sv/cutoff_coulomb_pair_potential_assert.svh
// Assertion macros shared by the pair potential RTL.
`ifndef CUTOFF_COULOMB_PAIR_POTENTIAL_ASSERT_SVH
`define CUTOFF_COULOMB_PAIR_POTENTIAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCPP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cutoff_coulomb_pair_potential: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cutoff_coulomb_pair_potential: next-cycle check failed");

`endif

// File: sv/ccpp_pkg.sv
`default_nettype none

package ccpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 40;

    // Intermediate magnitudes clamp at 2^41, so they need 42 bits.
    localparam int MAG_W = 42;
    typedef logic [MAG_W-1:0] mag_t;
    localparam mag_t MAG_CLAMP = {1'b1, {(MAG_W-1){1'b0}}};

    // Inverse distance 2^(2*FRAC_BITS) / distance, one quotient bit per stage.
    localparam int QUO_W   = 2 * FRAC_BITS + 1;
    localparam int DIV_LAT = QUO_W;
    localparam int MUL_LAT = 3;
    localparam int EXP_LAT = 3;

    // exp(-x) table on [0,32], Q32 entries.
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_IDX_W  = 8;
    localparam int EXP_SPAN_W = 5;
    localparam int EXP_X_W    = EXP_SPAN_W + FRAC_BITS;
    localparam int EXP_FR_W   = EXP_X_W - EXP_IDX_W;
    localparam int TAB_W      = 33;
    localparam int EX_W       = FRAC_BITS + 1;
    localparam int TAB_FRAC   = 56;

    typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_DEPTH];

    localparam logic [1:0] KIND_EE = 2'd0;
    localparam logic [1:0] KIND_II = 2'd1;
    localparam logic [1:0] KIND_EI = 2'd2;

    localparam logic [2:0] REG_ION_CHARGE  = 3'd0;
    localparam logic [2:0] REG_EI_CAP      = 3'd1;
    localparam logic [2:0] REG_EE_CAP      = 3'd2;
    localparam logic [2:0] REG_EE_CAP_EN   = 3'd3;
    localparam logic [2:0] REG_PAULI_EN    = 3'd4;
    localparam logic [2:0] REG_INV_PAULI_L = 3'd5;

    function automatic logic [63:0] mul_shr_tab(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[TAB_FRAC +: 64];
    endfunction

    // Taylor series for exp(-step), then repeated products for each point.
    function automatic exp_tab_t exp_tab_build();
        exp_tab_t    tab;
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] cur;
        logic [63:0] rnd;
        one  = 64'd1 << TAB_FRAC;
        y    = (64'd32 << TAB_FRAC) / EXP_DEPTH;
        term = one;
        sum  = one;
        cur  = one;
        rnd  = 64'd1 << 23;
        for (int n = 1; n < 24; n++) begin
            term = mul_shr_tab(term, y) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        tab[0] = TAB_W'((one + rnd) >> 24);
        for (int i = 1; i <= EXP_DEPTH; i++) begin
            cur    = mul_shr_tab(cur, sum);
            tab[i] = TAB_W'((cur + rnd) >> 24);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_tab_build();

endpackage

`default_nettype wire

// File: sv/cutoff_coulomb_pair_potential.sv
// Throughput: one request per cycle; the 33-stage inverse-distance divider,
// seven 3-stage multipliers and the 3-stage exp lookup are all fully pipelined.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits, holds s_tready low
// and loads the configuration registers with their defaults.
`default_nettype none

module cutoff_coulomb_pair_potential (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port.
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wdata,
    // Request channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // [23:0] distance
    input  wire logic [1:0]   s_tuser,   // [1:0] func (pair kind)
    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,   // [39:0] energy, [79:40] force_res,
                                         // [119:80] quantum_energy
    output logic [0:0]        m_tuser    // [0] saturated
);
    import ccpp_pkg::*;

    // One record carries everything a request needs down the pipeline. Each
    // section fills in the fields it produces.
    typedef struct packed {
        logic            valid;
        logic [1:0]      kind;
        logic            zero;
        logic [IN_W-1:0] distance;
        mag_t            rinv;
        mag_t            p0;     // rinv*rinv, rinv*q*q or rinv*q by kind
        mag_t            rl;     // R/L
        mag_t            kp;     // p0*rinv
        mag_t            x;      // (R/L)^2
        logic [EX_W-1:0] ex;     // exp(-x)
        mag_t            t1;     // ex*R/L
        mag_t            xe;     // x*ex
    } pl_t;

    // ------------------------------------------------------------------
    // Configuration registers. Products that depend on configuration only are
    // refreshed every cycle; users must read them long after a write; unenforced.
    // ------------------------------------------------------------------
    logic [IN_W-1:0] ion_charge_reg;
    logic [IN_W-1:0] ei_cap_reg;
    logic [IN_W-1:0] ee_cap_reg;
    logic            ee_cap_en_reg;
    logic            pauli_en_reg;
    logic [IN_W-1:0] inv_pauli_reg;
    logic [31:0]     qq_reg;
    logic [31:0]     eicq_reg;
    logic [2*IN_W-1:0] qq_full;
    logic [2*IN_W-1:0] eicq_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ion_charge_reg <= IN_W'(65536);
            ei_cap_reg     <= IN_W'(65536);
            ee_cap_reg     <= IN_W'(65536);
            ee_cap_en_reg  <= 1'b0;
            pauli_en_reg   <= 1'b1;
            inv_pauli_reg  <= IN_W'(65536);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ION_CHARGE:  ion_charge_reg <= cfg_wdata;
                REG_EI_CAP:      ei_cap_reg     <= cfg_wdata;
                REG_EE_CAP:      ee_cap_reg     <= cfg_wdata;
                REG_EE_CAP_EN:   ee_cap_en_reg  <= cfg_wdata[0];
                REG_PAULI_EN:    pauli_en_reg   <= cfg_wdata[0];
                REG_INV_PAULI_L: inv_pauli_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Squares of a 24-bit Q8.16 value stay below 2^32 after the shift, so
    // these never reach the clamp.
    assign qq_full   = {{IN_W{1'b0}}, ion_charge_reg} * {{IN_W{1'b0}}, ion_charge_reg};
    assign eicq_full = {{IN_W{1'b0}}, ei_cap_reg} * {{IN_W{1'b0}}, ion_charge_reg};

    always_ff @(posedge aclk) begin
        qq_reg   <= qq_full[FRAC_BITS +: 32];
        eicq_reg <= eicq_full[FRAC_BITS +: 32];
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances whenever the output
    // register is empty or being drained. No request is taken in reset.
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic adv;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && aresetn;

    // ------------------------------------------------------------------
    // Pipeline sections.
    // ------------------------------------------------------------------
    pl_t div_line_reg [0:DIV_LAT-1];
    pl_t m1_reg [0:MUL_LAT-1];
    pl_t m2_reg [0:MUL_LAT-1];
    pl_t ex_reg [0:EXP_LAT-1];
    pl_t m3_reg [0:MUL_LAT-1];
    pl_t m4_reg [0:MUL_LAT-1];

    pl_t div_entry, m1_entry, m2_entry, ex_entry, m3_entry, m4_entry, fin;

    logic [QUO_W-1:0] quotient;
    mag_t u0_b;
    mag_t u0_p, u1_p, u2_p, u3_p, u4_p, u5_p, u6_p;

    ccpp_div u_div (
        .aclk     (aclk),
        .en       (adv),
        .divisor  (s_tdata),
        .quotient (quotient)
    );

    always_comb begin
        div_entry          = '0;
        div_entry.valid    = s_tvalid;
        div_entry.kind     = s_tuser;
        div_entry.distance = s_tdata;
    end

    // Zero distance stands for an infinite inverse distance: the clamp value.
    always_comb begin
        m1_entry      = div_line_reg[DIV_LAT-1];
        m1_entry.zero = (m1_entry.distance == '0);
        m1_entry.rinv = m1_entry.zero ? MAG_CLAMP
                                      : {{(MAG_W-QUO_W){1'b0}}, quotient};
        case (m1_entry.kind)
            KIND_EE: u0_b = m1_entry.rinv;
            KIND_II: u0_b = {{(MAG_W-32){1'b0}}, qq_reg};
            default: u0_b = {{(MAG_W-IN_W){1'b0}}, ion_charge_reg};
        endcase
    end

    ccpp_mulq u_mul0 (.aclk(aclk), .en(adv), .a(m1_entry.rinv), .b(u0_b), .p(u0_p));
    ccpp_mulq u_mul1 (
        .aclk (aclk),
        .en   (adv),
        .a    ({{(MAG_W-IN_W){1'b0}}, m1_entry.distance}),
        .b    ({{(MAG_W-IN_W){1'b0}}, inv_pauli_reg}),
        .p    (u1_p)
    );

    always_comb begin
        m2_entry    = m1_reg[MUL_LAT-1];
        m2_entry.p0 = u0_p;
        m2_entry.rl = u1_p;
    end

    ccpp_mulq u_mul2 (.aclk(aclk), .en(adv), .a(m2_entry.p0), .b(m2_entry.rinv), .p(u2_p));
    ccpp_mulq u_mul3 (.aclk(aclk), .en(adv), .a(m2_entry.rl), .b(m2_entry.rl), .p(u3_p));

    always_comb begin
        ex_entry    = m2_reg[MUL_LAT-1];
        ex_entry.kp = u2_p;
        ex_entry.x  = u3_p;
    end

    // exp(-x): table lookup, slope times fraction, then interpolate and round.
    logic                 ex1_big_reg;
    logic [TAB_W-1:0]     ex1_t0_reg;
    logic [TAB_W-1:0]     ex1_diff_reg;
    logic [EXP_FR_W-1:0]  ex1_frac_reg;
    logic                 ex2_big_reg;
    logic [TAB_W-1:0]     ex2_t0_reg;
    logic [TAB_W+EXP_FR_W-1:0] ex2_prod_reg;
    logic [EX_W-1:0]      ex3_reg;

    logic [EXP_IDX_W:0]   ex_idx;
    logic [TAB_W-1:0]     ex_t0, ex_t1;
    logic [TAB_W-1:0]     ex_v;
    logic [TAB_W:0]       ex_rnd;
    logic [EX_W-1:0]      ex3_next;

    always_comb begin
        ex_idx   = {1'b0, ex_entry.x[EXP_X_W-1:EXP_FR_W]};
        ex_t0    = EXP_TAB[ex_idx];
        ex_t1    = EXP_TAB[ex_idx + (EXP_IDX_W+1)'(1)];
        ex_v     = ex2_t0_reg - TAB_W'(ex2_prod_reg >> EXP_FR_W);
        ex_rnd   = {1'b0, ex_v} + ((TAB_W+1)'(1) << (31 - FRAC_BITS));
        ex3_next = ex2_big_reg ? '0 : ex_rnd[(32 - FRAC_BITS) +: EX_W];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ex1_big_reg  <= (ex_entry.x[MAG_W-1:EXP_X_W] != '0);
            ex1_t0_reg   <= ex_t0;
            ex1_diff_reg <= ex_t0 - ex_t1;
            ex1_frac_reg <= ex_entry.x[EXP_FR_W-1:0];
            ex2_big_reg  <= ex1_big_reg;
            ex2_t0_reg   <= ex1_t0_reg;
            ex2_prod_reg <= {{EXP_FR_W{1'b0}}, ex1_diff_reg}
                          * {{TAB_W{1'b0}}, ex1_frac_reg};
            ex3_reg      <= ex3_next;
        end
    end

    always_comb begin
        m3_entry    = ex_reg[EXP_LAT-1];
        m3_entry.ex = ex3_reg;
    end

    ccpp_mulq u_mul4 (
        .aclk (aclk),
        .en   (adv),
        .a    ({{(MAG_W-EX_W){1'b0}}, m3_entry.ex}),
        .b    (m3_entry.rl),
        .p    (u4_p)
    );
    ccpp_mulq u_mul5 (
        .aclk (aclk),
        .en   (adv),
        .a    (m3_entry.x),
        .b    ({{(MAG_W-EX_W){1'b0}}, m3_entry.ex}),
        .p    (u5_p)
    );

    always_comb begin
        m4_entry    = m3_reg[MUL_LAT-1];
        m4_entry.t1 = u4_p;
        m4_entry.xe = u5_p;
    end

    ccpp_mulq u_mul6 (
        .aclk (aclk),
        .en   (adv),
        .a    (m4_entry.t1),
        .b    ({{(MAG_W-IN_W){1'b0}}, inv_pauli_reg}),
        .p    (u6_p)
    );

    assign fin = m4_reg[MUL_LAT-1];

    // Side records shift in lockstep with the arithmetic units.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                div_line_reg[i].valid <= 1'b0;
            end
            for (int i = 0; i < MUL_LAT; i++) begin
                m1_reg[i].valid <= 1'b0;
                m2_reg[i].valid <= 1'b0;
                m3_reg[i].valid <= 1'b0;
                m4_reg[i].valid <= 1'b0;
            end
            for (int i = 0; i < EXP_LAT; i++) begin
                ex_reg[i].valid <= 1'b0;
            end
        end else if (adv) begin
            div_line_reg[0] <= div_entry;
            for (int i = 1; i < DIV_LAT; i++) begin
                div_line_reg[i] <= div_line_reg[i-1];
            end
            m1_reg[0] <= m1_entry;
            m2_reg[0] <= m2_entry;
            m3_reg[0] <= m3_entry;
            m4_reg[0] <= m4_entry;
            for (int i = 1; i < MUL_LAT; i++) begin
                m1_reg[i] <= m1_reg[i-1];
                m2_reg[i] <= m2_reg[i-1];
                m3_reg[i] <= m3_reg[i-1];
                m4_reg[i] <= m4_reg[i-1];
            end
            ex_reg[0] <= ex_entry;
            for (int i = 1; i < EXP_LAT; i++) begin
                ex_reg[i] <= ex_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final combine. Every term is a nonnegative magnitude of at most 2^41,
    // so a 45-bit signed sum cannot wrap before saturation to 40 bits.
    // ------------------------------------------------------------------
    localparam int SUM_W = MAG_W + 3;
    localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'((64'sd1 <<< (OUT_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] OUT_MIN_S = -SUM_W'(64'sd1 <<< (OUT_W-1));

    logic signed [SUM_W-1:0] rinv_s, p0_s, kp_s, half_ex_s, half_xe_s, t2_s;
    logic signed [SUM_W-1:0] e_s, k_s, q_s;
    logic signed [SUM_W-1:0] e_sat, k_sat, q_sat;
    logic                    ee_capped, ei_capped, is_ei, clip;

    logic [OUT_W-1:0] energy_reg, force_reg, quantum_reg;
    logic             sat_reg;
    logic             out_zero_reg, out_eicap_reg, out_ei_reg;

    always_comb begin
        rinv_s    = $signed({3'b000, fin.rinv});
        p0_s      = $signed({3'b000, fin.p0});
        kp_s      = $signed({3'b000, fin.kp});
        half_ex_s = $signed({{(SUM_W-EX_W){1'b0}}, fin.ex} >> 1);
        half_xe_s = $signed({3'b000, fin.xe} >> 1);
        t2_s      = $signed({3'b000, u6_p});
        ee_capped = ee_cap_en_reg && (fin.rinv > {{(MAG_W-IN_W){1'b0}}, ee_cap_reg});
        ei_capped = (fin.rinv > {{(MAG_W-IN_W){1'b0}}, ei_cap_reg});
        is_ei     = 1'b0;

        case (fin.kind)
            KIND_EE: begin
                if (ee_capped) begin
                    e_s = $signed({{(SUM_W-IN_W){1'b0}}, ee_cap_reg});
                    k_s = '0;
                    q_s = '0;
                end else begin
                    e_s = rinv_s;
                    k_s = p0_s;
                    q_s = rinv_s;
                end
                if (pauli_en_reg) begin
                    e_s = e_s + half_ex_s;
                    k_s = k_s + t2_s;
                    q_s = q_s + half_ex_s + half_xe_s;
                end
            end
            KIND_II: begin
                e_s = p0_s;
                k_s = kp_s;
                q_s = p0_s;
            end
            default: begin
                // Electron-ion; the unused kind code takes this path too.
                is_ei = 1'b1;
                if (ei_capped) begin
                    e_s = -$signed({{(SUM_W-32){1'b0}}, eicq_reg});
                    k_s = '0;
                    q_s = '0;
                end else begin
                    e_s = -p0_s;
                    k_s = -kp_s;
                    q_s = -p0_s;
                end
            end
        endcase

        clip  = fin.zero;
        e_sat = e_s;
        k_sat = k_s;
        q_sat = q_s;
        if (e_s > OUT_MAX_S) begin e_sat = OUT_MAX_S; clip = 1'b1; end
        if (e_s < OUT_MIN_S) begin e_sat = OUT_MIN_S; clip = 1'b1; end
        if (k_s > OUT_MAX_S) begin k_sat = OUT_MAX_S; clip = 1'b1; end
        if (k_s < OUT_MIN_S) begin k_sat = OUT_MIN_S; clip = 1'b1; end
        if (q_s > OUT_MAX_S) begin q_sat = OUT_MAX_S; clip = 1'b1; end
        if (q_s < OUT_MIN_S) begin q_sat = OUT_MIN_S; clip = 1'b1; end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            energy_reg    <= e_sat[OUT_W-1:0];
            force_reg     <= k_sat[OUT_W-1:0];
            quantum_reg   <= q_sat[OUT_W-1:0];
            sat_reg       <= clip;
            out_zero_reg  <= fin.zero;
            out_eicap_reg <= is_ei && ei_capped;
            out_ei_reg    <= is_ei;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {quantum_reg, force_reg, energy_reg};
    assign m_tuser  = sat_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "cutoff_coulomb_pair_potential_assert.svh"

    `CCPP_ASSERT_SAME(a_zero_dist_saturates, aclk, aresetn,
        m_valid_reg && out_zero_reg, sat_reg)
    `CCPP_ASSERT_SAME(a_ei_cap_zero_force, aclk, aresetn,
        m_valid_reg && out_eicap_reg, force_reg == '0)
    `CCPP_ASSERT_SAME(a_repulsive_force_sign, aclk, aresetn,
        m_valid_reg && !out_ei_reg, !force_reg[OUT_W-1])
    `CCPP_ASSERT_NEXT(a_stall_holds_tail, aclk, aresetn,
        !adv && fin.valid, m4_reg[MUL_LAT-1].valid)

endmodule

`default_nettype wire

// File: sv/ccpp_mulq.sv
`default_nettype none

module ccpp_mulq (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire ccpp_pkg::mag_t a,
    input  wire ccpp_pkg::mag_t b,
    output ccpp_pkg::mag_t     p
);
    import ccpp_pkg::*;

    localparam int HW = MAG_W / 2;
    localparam int SW = 2 * MAG_W;

    // Four half-width partial products, then the sum, then shift and clamp.
    logic [MAG_W-1:0]      ll_reg, lh_reg, hl_reg, hh_reg;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [SW-FRAC_BITS-1:0] shifted;
    mag_t                  p_reg, p_next;

    always_comb begin
        sum_next = {{MAG_W{1'b0}}, ll_reg}
                 + ({{MAG_W{1'b0}}, lh_reg} << HW)
                 + ({{MAG_W{1'b0}}, hl_reg} << HW)
                 + {hh_reg, {MAG_W{1'b0}}};
        shifted  = sum_reg[SW-1:FRAC_BITS];
        if (shifted > {{(SW-FRAC_BITS-MAG_W){1'b0}}, MAG_CLAMP}) begin
            p_next = MAG_CLAMP;
        end else begin
            p_next = shifted[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
            lh_reg  <= {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[MAG_W-1:HW]};
            hl_reg  <= {{HW{1'b0}}, a[MAG_W-1:HW]} * {{HW{1'b0}}, b[HW-1:0]};
            hh_reg  <= {{HW{1'b0}}, a[MAG_W-1:HW]} * {{HW{1'b0}}, b[MAG_W-1:HW]};
            sum_reg <= sum_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: sv/ccpp_div.sv
`default_nettype none

module ccpp_div (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [ccpp_pkg::IN_W-1:0]   divisor,
    output logic      [ccpp_pkg::QUO_W-1:0]  quotient
);
    import ccpp_pkg::*;

    // Restoring division of 2^(QUO_W-1) by the divisor, one bit per stage.
    logic [IN_W-1:0]  rem_reg [0:DIV_LAT-1];
    logic [IN_W-1:0]  dv_reg  [0:DIV_LAT-1];
    logic [QUO_W-1:0] quo_reg [0:DIV_LAT-1];

    for (genvar s = 0; s < DIV_LAT; s++) begin : g_step
        logic [IN_W-1:0]  rin;
        logic [IN_W-1:0]  dvin;
        logic [QUO_W-1:0] qin;
        logic [IN_W:0]    sh;
        logic [IN_W:0]    diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign rin  = '0;
            assign dvin = divisor;
            assign qin  = '0;
            assign sh   = {rin, 1'b1};
        end else begin : g_rest
            assign rin  = rem_reg[s-1];
            assign dvin = dv_reg[s-1];
            assign qin  = quo_reg[s-1];
            assign sh   = {rin, 1'b0};
        end

        assign diff = sh - {1'b0, dvin};
        assign ge   = (sh >= {1'b0, dvin});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? diff[IN_W-1:0] : sh[IN_W-1:0];
                dv_reg[s]  <= dvin;
                quo_reg[s] <= qin | (ge ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
            end
        end
    end

    assign quotient = quo_reg[DIV_LAT-1];

endmodule

`default_nettype wire

// File: sim/cutoff_coulomb_pair_potential_tb.sv
`default_nettype none

module cutoff_coulomb_pair_potential_tb;
    import ccpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth pair kind code is unused by the block and behaves as electron-ion.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int  PIPE_DRAIN  = 64;       // comfortably above the block's latency
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint OUT_HI   = (64'sd1 <<< 39) - 1;
    localparam longint OUT_LO   = -(64'sd1 <<< 39);
    localparam longint MAG_TOP  = 64'sd1 <<< 41;

    typedef struct packed {
        logic [39:0] energy;
        logic [39:0] force_res;
        logic [39:0] quantum;
        logic        saturated;
    } pair_result_t;

    // One row of the directed table. When known is set, the expected result is
    // the typed-in value; otherwise the predictor supplies it.
    typedef struct {
        logic [1:0]   kind;
        logic [23:0]  distance;
        bit           known;
        pair_result_t want;
    } pair_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [0:0]   m_tuser;

    cutoff_coulomb_pair_potential DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the configuration, kept in step with every register write.
    longint unsigned charge_q, ei_cap_q, ee_cap_q, inv_len_q;
    bit              ee_cap_on, pauli_on;

    // Samples of exp(-x) on [0,32] in Q32, built once at the start.
    longint unsigned gauss_pts [0:EXP_DEPTH];

    pair_result_t pending_results [$];
    int  mismatches;
    int  results_seen;
    int  requests_sent;
    int  cycles;
    bit  quiet;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // floor(a*b / 2^s) on 64-bit magnitudes; all ones when the quotient overflows.
    function automatic longint unsigned scaled_product(longint unsigned a,
                                                      longint unsigned b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + s)) != 0) begin
            return '1;
        end
        return 64'(p >> s);
    endfunction

    // Fixed-point product with the intermediate magnitude clamp.
    function automatic longint fx_mul(longint a, longint b);
        longint unsigned r;
        r = scaled_product(longint'(a), longint'(b), FRAC_BITS);
        return (r > longint'(MAG_TOP)) ? MAG_TOP : longint'(r);
    endfunction

    function automatic void build_gauss_points();
        longint unsigned unit, step, term, series, acc;
        unit   = 64'd1 << TAB_FRAC;
        step   = (64'd32 << TAB_FRAC) / EXP_DEPTH;
        term   = unit;
        series = unit;
        acc    = unit;
        // Taylor series of exp(-step); each table point is the previous one times it.
        for (int n = 1; n < 24; n++) begin
            term = scaled_product(term, step, TAB_FRAC) / longint'(n);
            if (n % 2 == 1) begin
                series = series - term;
            end else begin
                series = series + term;
            end
        end
        gauss_pts[0] = (unit + (64'd1 << 23)) >> 24;
        for (int i = 1; i <= EXP_DEPTH; i++) begin
            acc          = scaled_product(acc, series, TAB_FRAC);
            gauss_pts[i] = (acc + (64'd1 << 23)) >> 24;
        end
    endfunction

    // exp(-x) by linear interpolation between table points, rounded to FRAC_BITS.
    function automatic longint gauss_decay(longint x);
        longint unsigned span, pos, idx, frac, t0, t1, v;
        span = 64'd32 << FRAC_BITS;
        if (longint'(x) >= span) begin
            return 0;
        end
        pos  = longint'(x) * EXP_DEPTH;
        idx  = pos / span;
        frac = pos % span;
        if (idx >= EXP_DEPTH) begin
            return 0;
        end
        t0 = gauss_pts[idx];
        t1 = gauss_pts[idx + 1];
        v  = t0 - ((t0 - t1) * frac) / span;
        return longint'((v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    endfunction

    function automatic logic [39:0] clip40(longint v, inout bit clipped);
        if (v > OUT_HI) begin
            v = OUT_HI;
            clipped = 1'b1;
        end
        if (v < OUT_LO) begin
            v = OUT_LO;
            clipped = 1'b1;
        end
        return v[39:0];
    endfunction

    // Energy, force term and quantum energy for one pair under the current settings.
    function automatic pair_result_t coulomb_predict(logic [1:0] kind, logic [23:0] distance);
        longint rinv, e, k, qe, rl, x, ex, m;
        bit clipped;
        pair_result_t r;
        clipped = 1'b0;
        if (distance == 0) begin
            // A zero separation acts as infinite inverse distance.
            rinv    = MAG_TOP;
            clipped = 1'b1;
        end else begin
            rinv = longint'((64'd1 << (2 * FRAC_BITS)) / longint'(distance));
            if (rinv > MAG_TOP) begin
                rinv = MAG_TOP;
            end
        end
        if (kind == KIND_II) begin
            e  = fx_mul(rinv, fx_mul(charge_q, charge_q));
            k  = fx_mul(e, rinv);
            qe = e;
        end else if (kind == KIND_EE) begin
            if (ee_cap_on && rinv > longint'(ee_cap_q)) begin
                e  = ee_cap_q;
                k  = 0;
                qe = 0;
            end else begin
                e  = rinv;
                k  = fx_mul(rinv, rinv);
                qe = rinv;
            end
            if (pauli_on) begin
                rl = fx_mul(longint'(distance), inv_len_q);
                x  = fx_mul(rl, rl);
                ex = gauss_decay(x);
                e  = e + (ex >>> 1);
                k  = k + fx_mul(fx_mul(ex, rl), inv_len_q);
                qe = qe + (ex >>> 1) + (fx_mul(x, ex) >>> 1);
            end
        end else begin
            // Electron-ion, and the spare kind code that falls through to it.
            if (rinv > longint'(ei_cap_q)) begin
                e  = -fx_mul(ei_cap_q, charge_q);
                k  = 0;
                qe = 0;
            end else begin
                m  = fx_mul(rinv, charge_q);
                e  = -m;
                k  = -fx_mul(m, rinv);
                qe = e;
            end
        end
        r.energy    = clip40(e, clipped);
        r.force_res = clip40(k, clipped);
        r.quantum   = clip40(qe, clipped);
        r.saturated = clipped;
        return r;
    endfunction

    // Writes all six registers on consecutive edges; the write enable stays high
    // across them and drops once after the last one.
    task automatic load_settings(longint unsigned chg, longint unsigned ei_cap,
                                 longint unsigned ee_cap, bit ee_on, bit p_on,
                                 longint unsigned inv_len);
        logic [2:0]  addr [6];
        logic [23:0] data [6];
        addr = '{REG_ION_CHARGE, REG_EI_CAP, REG_EE_CAP, REG_EE_CAP_EN,
                 REG_PAULI_EN, REG_INV_PAULI_L};
        data = '{chg[23:0], ei_cap[23:0], ee_cap[23:0], {23'd0, ee_on},
                 {23'd0, p_on}, inv_len[23:0]};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        charge_q  = chg[23:0];
        ei_cap_q  = ei_cap[23:0];
        ee_cap_q  = ee_cap[23:0];
        ee_cap_on = ee_on;
        pauli_on  = p_on;
        inv_len_q = inv_len[23:0];
    endtask

    // Offers one request and holds it until the block takes it. The prediction
    // is queued at the edge where the request is accepted.
    task automatic send_pair(logic [1:0] kind, logic [23:0] distance, bit known,
                             pair_result_t want);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= distance;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(known ? want : coulomb_predict(kind, distance));
        requests_sent++;
    endtask

    // A random pause on the request side; s_tvalid drops only when a gap is taken.
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Distances are drawn from several bands so that zero, tiny separations
    // (huge inverse distance), the region around 1.0 where the Pauli term is
    // alive, and the far end all show up often.
    function automatic logic [23:0] pick_distance();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'($urandom_range(1, 255));
            2, 3: return 24'($urandom_range(24'h004000, 24'h060000));
            4: return 24'hFFFFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_setting();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(24'h002000, 24'h080000));
        endcase
    endfunction

    // Result side: compares every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        pair_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h / %b", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[39:0] !== want.energy) begin
                    $error("energy: expected %h, got %h", want.energy, m_tdata[39:0]);
                    mismatches++;
                end
                if (m_tdata[79:40] !== want.force_res) begin
                    $error("force_res: expected %h, got %h", want.force_res,
                           m_tdata[79:40]);
                    mismatches++;
                end
                if (m_tdata[119:80] !== want.quantum) begin
                    $error("quantum_energy: expected %h, got %h", want.quantum,
                           m_tdata[119:80]);
                    mismatches++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Receiver back-pressure: ready bursts alternate with stall bursts until the
    // final phase, where the receiver always accepts.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (quiet) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                if (!quiet) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        pair_row_t    rows [$];
        pair_result_t none;
        logic [1:0]   kind;
        int           phase_len;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        quiet     = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        cycles        = 0;
        none          = '0;

        build_gauss_points();
        // Register defaults after reset.
        charge_q  = 65536;
        ei_cap_q  = 65536;
        ee_cap_q  = 65536;
        ee_cap_on = 1'b0;
        pauli_on  = 1'b1;
        inv_len_q = 65536;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, at the reset settings. Results are typed in where they
        // follow directly: unit charge at unit distance, and zero distance, which
        // either saturates everything or hits the electron-ion cap.
        rows = '{
            '{KIND_II,    24'h010000, 1'b1, '{40'h0000010000, 40'h0000010000,
                                              40'h0000010000, 1'b0}},
            '{KIND_EI,    24'h010000, 1'b1, '{40'hFFFFFF0000, 40'hFFFFFF0000,
                                              40'hFFFFFF0000, 1'b0}},
            '{KIND_EI,    24'h000000, 1'b1, '{40'hFFFFFF0000, 40'h0, 40'h0, 1'b1}},
            '{KIND_SPARE, 24'h000000, 1'b1, '{40'hFFFFFF0000, 40'h0, 40'h0, 1'b1}},
            '{KIND_II,    24'h000000, 1'b1, '{40'h7FFFFFFFFF, 40'h7FFFFFFFFF,
                                              40'h7FFFFFFFFF, 1'b1}},
            '{KIND_EE,    24'h000000, 1'b0, none},
            '{KIND_EE,    24'h010000, 1'b0, none},
            '{KIND_EE,    24'h008000, 1'b0, none},
            '{KIND_EE,    24'h05A000, 1'b0, none},
            '{KIND_EE,    24'h000001, 1'b0, none},
            '{KIND_II,    24'h000001, 1'b0, none},
            '{KIND_EI,    24'h000001, 1'b0, none},
            '{KIND_EE,    24'hFFFFFF, 1'b0, none},
            '{KIND_II,    24'hFFFFFF, 1'b0, none},
            '{KIND_EI,    24'hFFFFFF, 1'b0, none},
            '{KIND_SPARE, 24'hFFFFFF, 1'b0, none},
            '{KIND_SPARE, 24'h008000, 1'b0, none},
            '{KIND_EI,    24'h00FFFF, 1'b0, none},
            '{KIND_EI,    24'h010001, 1'b0, none},
            '{KIND_II,    24'hAAAAAA, 1'b0, none},
            '{KIND_EE,    24'h555555, 1'b0, none}
        };
        foreach (rows[i]) begin
            send_pair(rows[i].kind, rows[i].distance, rows[i].known, rows[i].want);
            sender_gap();
        end

        // Random phases. Each phase starts from an idle block with a fresh set of
        // register values: all-ones extremes first, then zeros with both enables set
        // (which also makes the Pauli length reciprocal zero), then one fixed set,
        // then random settings. The last phase runs with no idling on either side.
        for (int phase = 0; phase < 7; phase++) begin
            drain_results();
            repeat (PIPE_DRAIN) @(posedge aclk);
            case (phase)
                0: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF);
                1: load_settings(0, 0, 0, 1'b1, 1'b1, 0);
                2: load_settings(24'h010000, 24'h000100, 24'h000100, 1'b0, 1'b0, 24'h020000);
                default: load_settings(pick_setting(), pick_setting(), pick_setting(),
                                       1'($urandom), 1'($urandom), pick_setting());
            endcase
            quiet     = (phase == 6);
            phase_len = 62;
            for (int n = 0; n < phase_len; n++) begin
                kind = 2'($urandom_range(0, 3));
                send_pair(kind, pick_distance(), 1'b0, none);
                // Midway through one phase the sender holds off until the
                // pipeline has handed back every outstanding result.
                if (phase == 3 && n == phase_len / 2) begin
                    drain_results();
                end else begin
                    sender_gap();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DRAIN) @(posedge aclk);

        $display("Sent %0d pair requests over reset, extreme, zero and random settings;",
                 requests_sent);
        $display("checked %0d results for all pair kinds, zero and extreme distances.",
                 results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
